// File: rtl/imu_mounting_frame_calibrator_macros.svh
// assertion helpers shared by the calibrator rtl
`ifndef IMU_MOUNTING_FRAME_CALIBRATOR_MACROS_SVH
`define IMU_MOUNTING_FRAME_CALIBRATOR_MACROS_SVH

// checked only while out of reset
`define IMFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define IMFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/imfc_pkg.sv
package imfc_pkg;

    typedef logic [2:0] frame_t;
    typedef logic [1:0] axis_t;

    localparam frame_t FRAME_POS_X = 3'd0;
    localparam frame_t FRAME_NEG_X = 3'd1;
    localparam frame_t FRAME_POS_Y = 3'd2;
    localparam frame_t FRAME_NEG_Y = 3'd3;
    localparam frame_t FRAME_POS_Z = 3'd4;
    localparam frame_t FRAME_NEG_Z = 3'd5;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_ARM    = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORM_SQ_LOW  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORM_SQ_HIGH = 1'b1;

    localparam int NORM_W = 32;
    localparam logic [NORM_W-1:0] NORM_SQ_LOW_RST  = 32'd0;
    localparam logic [NORM_W-1:0] NORM_SQ_HIGH_RST = 32'd3221225472;

    // source axis feeding body axis "axis" in frame f
    function automatic axis_t frame_src(input frame_t f, input axis_t axis);
        axis_t rot;
        case (f)
            FRAME_POS_Y, FRAME_NEG_Y: rot = 2'd1;
            FRAME_POS_Z, FRAME_NEG_Z: rot = 2'd2;
            default:                  rot = 2'd0;
        endcase
        case (axis)
            AXIS_X:  frame_src = (rot == 2'd0) ? AXIS_X : ((rot == 2'd1) ? AXIS_Y : AXIS_Z);
            AXIS_Y:  frame_src = (rot == 2'd0) ? AXIS_Y : ((rot == 2'd1) ? AXIS_Z : AXIS_X);
            default: frame_src = (rot == 2'd0) ? AXIS_Z : ((rot == 2'd1) ? AXIS_X : AXIS_Y);
        endcase
    endfunction

    // bit i set: body axis i is negated
    function automatic logic [2:0] frame_neg(input frame_t f);
        case (f)
            FRAME_NEG_X, FRAME_NEG_Y, FRAME_NEG_Z: frame_neg = 3'b101;
            FRAME_POS_Z:                           frame_neg = 3'b110;
            default:                               frame_neg = 3'b000;
        endcase
    endfunction

endpackage

// File: rtl/imu_mounting_frame_calibrator.sv
// IMU mounting-frame calibrator.
// Input stream (s_*): s_tuser is the mode (0 sample, 1 arm event), s_tdata carries
// accel x/y/z then gyro x/y/z, SAMPLE_BITS each, signed. Result stream (m_*): m_tdata
// carries the remapped body accel x/y/z and gyro x/y/z, m_tuser the frame in use,
// the window-open flag and the frame-committed flag. Every input transfer gives
// exactly one result transfer, in order.
// An arm event opens a calibration window; CAL_SAMPLES in-band samples in a row
// pick one of six mounting frames, and the sample that completes the window is
// already output in the new frame. The band is set over the cfg_* write port (index
// 0 low bound, 1 high bound); the user must write it only while no item is in flight,
// as the block does not enforce it. One item per cycle is taken sustained while
// m_tready stays high. Stage 1 registers the squared accel magnitude, stage 2 holds
// the window count, sums and frame register loop and the result register.
// Reset (aresetn low, synchronous) empties both stages, closes the window, clears
// the sums and selects frame 0 with the band at its reset values.
// When m_tready is low the result holds; stage 1 still fills, so one more item is
// taken before s_tready drops.
module imu_mounting_frame_calibrator #(
    parameter int CAL_SAMPLES = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, zero fill
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // mode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // body_accel_x, body_accel_y, body_accel_z, body_gyro_x, body_gyro_y,
    // body_gyro_z, zero fill
    output logic [((6*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    // frame_in_use[2:0], window_open, frame_committed
    output logic [4:0]                            m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [imfc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [imfc_pkg::NORM_W-1:0]           cfg_data
);

    `include "imu_mounting_frame_calibrator_macros.svh"

    localparam int TD_W  = ((6*SAMPLE_BITS+7)/8)*8;
    localparam int SQ_W  = 2*SAMPLE_BITS;
    localparam int CMP_W = (SQ_W > imfc_pkg::NORM_W) ? SQ_W : imfc_pkg::NORM_W;
    localparam int SUM_W = SAMPLE_BITS + $clog2(CAL_SAMPLES) + 1;
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    function automatic logic signed [SAMPLE_BITS-1:0] remap_axis(
        input logic signed [SAMPLE_BITS-1:0] v0,
        input logic signed [SAMPLE_BITS-1:0] v1,
        input logic signed [SAMPLE_BITS-1:0] v2,
        input imfc_pkg::axis_t               src,
        input logic                          neg
    );
        logic signed [SAMPLE_BITS-1:0] v;
        logic signed [SAMPLE_BITS-1:0] min_v;
        logic signed [SAMPLE_BITS-1:0] max_v;
        min_v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        max_v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        case (src)
            imfc_pkg::AXIS_X: v = v0;
            imfc_pkg::AXIS_Y: v = v1;
            default:          v = v2;
        endcase
        if (neg) begin
            v = (v == min_v) ? max_v : -v;
        end
        remap_axis = v;
    endfunction

    // configuration
    logic [imfc_pkg::NORM_W-1:0] norm_lo_reg;
    logic [imfc_pkg::NORM_W-1:0] norm_hi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_lo_reg <= imfc_pkg::NORM_SQ_LOW_RST;
            norm_hi_reg <= imfc_pkg::NORM_SQ_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                imfc_pkg::CFG_NORM_SQ_LOW:  norm_lo_reg <= cfg_data;
                imfc_pkg::CFG_NORM_SQ_HIGH: norm_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic p1_valid_reg;
    logic m_valid_reg;
    logic out_en;
    logic p1_en;
    logic adv2;

    assign out_en   = !m_valid_reg || m_tready;
    assign p1_en    = !p1_valid_reg || out_en;
    assign adv2     = p1_valid_reg && out_en;
    assign s_tready = p1_en;
    assign m_tvalid = m_valid_reg;

    // stage 1: unpack and squared magnitude
    logic signed [SAMPLE_BITS-1:0] in_acc [3];
    logic signed [SAMPLE_BITS-1:0] in_gyr [3];
    logic signed [SQ_W-1:0]        in_sq  [3];
    logic [SQ_W-1:0]               norm_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_acc[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            in_gyr[i] = s_tdata[(i+3)*SAMPLE_BITS +: SAMPLE_BITS];
            in_sq[i]  = in_acc[i] * in_acc[i];
        end
        norm_next = $unsigned(in_sq[0]) + $unsigned(in_sq[1]) + $unsigned(in_sq[2]);
    end

    logic                          p1_mode_reg;
    logic signed [SAMPLE_BITS-1:0] p1_acc_reg [3];
    logic signed [SAMPLE_BITS-1:0] p1_gyr_reg [3];
    logic [SQ_W-1:0]               p1_norm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_en && s_tvalid) begin
            p1_mode_reg <= s_tuser;
            p1_acc_reg  <= in_acc;
            p1_gyr_reg  <= in_gyr;
            p1_norm_reg <= norm_next;
        end
    end

    // stage 2: window state, frame choice, remap
    logic                    window_active_reg;
    logic                    window_active_next;
    logic [CNT_W-1:0]        window_cnt_reg;
    logic [CNT_W-1:0]        window_cnt_next;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic signed [SUM_W-1:0] sum_add  [3];
    logic [SUM_W-1:0]        sum_abs  [3];
    imfc_pkg::frame_t        frame_reg;
    imfc_pkg::frame_t        frame_next;
    imfc_pkg::frame_t        frame_pick;
    logic                    in_band;
    logic                    committed;
    logic [2:0]              neg_mask;
    logic signed [SAMPLE_BITS-1:0] body_acc [3];
    logic signed [SAMPLE_BITS-1:0] body_gyr [3];

    always_comb begin
        in_band = (CMP_W'(p1_norm_reg) >= CMP_W'(norm_lo_reg))
               && (CMP_W'(p1_norm_reg) <= CMP_W'(norm_hi_reg));
        cnt_inc = window_cnt_reg + 1'b1;
        for (int i = 0; i < 3; i++) begin
            sum_add[i] = sum_reg[i] + SUM_W'(p1_acc_reg[i]);
            sum_abs[i] = sum_add[i][SUM_W-1] ? $unsigned(-sum_add[i]) : $unsigned(sum_add[i]);
        end

        // ties go to x, then y; a zero sum picks the negative frame
        if (sum_abs[0] >= sum_abs[1] && sum_abs[0] >= sum_abs[2]) begin
            frame_pick = (!sum_add[0][SUM_W-1] && (sum_add[0] != '0))
                       ? imfc_pkg::FRAME_POS_X : imfc_pkg::FRAME_NEG_X;
        end else if (sum_abs[1] >= sum_abs[2]) begin
            frame_pick = (!sum_add[1][SUM_W-1] && (sum_add[1] != '0))
                       ? imfc_pkg::FRAME_POS_Y : imfc_pkg::FRAME_NEG_Y;
        end else begin
            frame_pick = (!sum_add[2][SUM_W-1] && (sum_add[2] != '0))
                       ? imfc_pkg::FRAME_POS_Z : imfc_pkg::FRAME_NEG_Z;
        end

        window_active_next = window_active_reg;
        window_cnt_next    = window_cnt_reg;
        sum_next           = sum_reg;
        frame_next         = frame_reg;
        committed          = 1'b0;

        if (p1_mode_reg == imfc_pkg::MODE_ARM) begin
            window_active_next = 1'b1;
            window_cnt_next    = '0;
            for (int i = 0; i < 3; i++) begin
                sum_next[i] = '0;
            end
        end else if (window_active_reg) begin
            if (!in_band) begin
                window_cnt_next = '0;
                for (int i = 0; i < 3; i++) begin
                    sum_next[i] = '0;
                end
            end else begin
                sum_next = sum_add;
                if (cnt_inc == CNT_W'(CAL_SAMPLES)) begin
                    frame_next         = frame_pick;
                    window_active_next = 1'b0;
                    window_cnt_next    = '0;
                    committed          = 1'b1;
                end else begin
                    window_cnt_next = cnt_inc;
                end
            end
        end

        // the completing sample already goes out in the new frame
        neg_mask = imfc_pkg::frame_neg(frame_next);
        for (int i = 0; i < 3; i++) begin
            body_acc[i] = remap_axis(p1_acc_reg[0], p1_acc_reg[1], p1_acc_reg[2],
                                     imfc_pkg::frame_src(frame_next, 2'(i)), neg_mask[i]);
            body_gyr[i] = remap_axis(p1_gyr_reg[0], p1_gyr_reg[1], p1_gyr_reg[2],
                                     imfc_pkg::frame_src(frame_next, 2'(i)), neg_mask[i]);
            if (p1_mode_reg == imfc_pkg::MODE_ARM) begin
                body_acc[i] = '0;
                body_gyr[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_active_reg <= 1'b0;
            window_cnt_reg    <= '0;
            frame_reg         <= imfc_pkg::FRAME_POS_X;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (adv2) begin
            window_active_reg <= window_active_next;
            window_cnt_reg    <= window_cnt_next;
            frame_reg         <= frame_next;
            sum_reg           <= sum_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_tdata <= TD_W'({body_gyr[2], body_gyr[1], body_gyr[0],
                              body_acc[2], body_acc[1], body_acc[0]});
            m_tuser <= {committed, window_active_next, frame_next};
        end
    end

    `IMFC_ASSERT(a_commit_closes, (m_tvalid && m_tuser[4]) |-> !m_tuser[3], "commit with window open")
    `IMFC_ASSERT(a_cnt_range, window_cnt_reg < CNT_W'(CAL_SAMPLES), "window count overrun")
    `IMFC_ASSERT(a_idle_cnt, !window_active_reg |-> (window_cnt_reg == '0), "count kept while idle")
    `IMFC_ASSERT(a_frame_range, frame_reg <= imfc_pkg::FRAME_NEG_Z, "frame code out of range")
    `IMFC_ASSERT(a_arm_opens, (adv2 && p1_mode_reg == imfc_pkg::MODE_ARM) |=> window_active_reg, "arm did not open window")
    `IMFC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
